[design/rvcd_pkg.sv]
// Shared types and constants for the RVC frame deframer.
package rvcd_pkg;

  localparam int unsigned FRAME_LEN = 19;
  localparam int unsigned CNT_W     = $clog2(FRAME_LEN + 1);

  typedef logic [7:0]       byte_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam byte_t SYNC_BYTE = 8'hAA;
  localparam cnt_t  CNT_FULL  = CNT_W'(FRAME_LEN);

endpackage

[design/rvcd_cell.sv]
// One byte cell of the deframer window shift chain.
module rvcd_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  rvcd_pkg::byte_t d_in,
  output rvcd_pkg::byte_t q
);

  rvcd_pkg::byte_t q_r;
  rvcd_pkg::byte_t q_nxt;

  always_comb begin
    q_nxt = shift_en ? d_in : q_r;
  end

  // Cleared at reset so the running checksum matches the chain contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[design/rvcd_chk.sv]
// Fill count, running checksum and frame match for the deframer window.
module rvcd_chk (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  rvcd_pkg::byte_t data_byte,
  input  rvcd_pkg::byte_t tap_w1,
  input  rvcd_pkg::byte_t tap_w2,
  input  rvcd_pkg::byte_t tap_w18,
  output logic            hit
);

  rvcd_pkg::cnt_t  cnt_r;
  rvcd_pkg::cnt_t  cnt_nxt;
  rvcd_pkg::cnt_t  cnt_adv;
  rvcd_pkg::byte_t sum_r;
  rvcd_pkg::byte_t sum_nxt;
  logic            hdr_ok;

  // Sum of positions 2..17 after the shift: drop old position 2, add old position 18.
  always_comb begin
    sum_nxt = shift_en ? (sum_r - tap_w2 + tap_w18) : sum_r;
    cnt_adv = (cnt_r == rvcd_pkg::CNT_FULL) ? cnt_r : cnt_r + 1'b1;
    hdr_ok  = (tap_w1 == rvcd_pkg::SYNC_BYTE) && (tap_w2 == rvcd_pkg::SYNC_BYTE);
    hit     = shift_en && (cnt_adv == rvcd_pkg::CNT_FULL) && hdr_ok
              && (sum_nxt == data_byte);
    if (hit) begin
      cnt_nxt = '0;
    end else if (shift_en) begin
      cnt_nxt = cnt_adv;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

[design/rvc_frame_deframer_core.sv]
// Top level of the RVC frame deframer: byte chain, frame check and result register.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data_byte) carries one received
//   serial byte per transfer, oldest first. The output channel (out_valid /
//   out_stall / out_*) carries one decoded frame per transfer: the index byte
//   and six little-endian signed 16-bit values (yaw, pitch, roll in 0.01 deg,
//   accelerations in 0.001 g).
//   Each accepted byte shifts into a 19-cell byte chain while a
//   running checksum and the header compare decide in that same cycle whether
//   the window now holds a valid frame. The result register loads at the end
//   of that cycle, so out_valid rises in the cycle after the completing byte transfer.
//   Throughput is one byte per cycle while in_stall is low.
//   Reset clears the fill count, the chain, the checksum and any pending
//   result. While a result is held and out_stall is high, in_stall is high
//   and no byte is taken; bytes flow again in the cycle the result is taken.
//   After a frame is found the window starts empty and needs 19 new bytes.
module rvc_frame_deframer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_frame_index,
  output logic signed [15:0] out_yaw,
  output logic signed [15:0] out_pitch,
  output logic signed [15:0] out_roll,
  output logic signed [15:0] out_accel_x,
  output logic signed [15:0] out_accel_y,
  output logic signed [15:0] out_accel_z
);

  localparam int unsigned LAST = rvcd_pkg::FRAME_LEN - 1;

  rvcd_pkg::byte_t win [rvcd_pkg::FRAME_LEN];
  logic            in_xfer;
  logic            hit;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [7:0]         idx_r;
  logic signed [15:0] yaw_r;
  logic signed [15:0] pitch_r;
  logic signed [15:0] roll_r;
  logic signed [15:0] ax_r;
  logic signed [15:0] ay_r;
  logic signed [15:0] az_r;

  // Hold input while a result waits and the receiver stalls.
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // Byte chain: every accepted byte enters at the tail and moves all others one position toward the head.
  for (genvar k = 0; k < rvcd_pkg::FRAME_LEN; k++) begin : g_cell
    rvcd_pkg::byte_t d_in;
    if (k == LAST) begin : g_tail
      assign d_in = in_data_byte;
    end else begin : g_body
      assign d_in = win[k+1];
    end
    rvcd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_xfer),
      .d_in     (d_in),
      .q        (win[k])
    );
  end

  // Frame match uses pre-shift taps: new positions 0 and 1 are old 1 and 2.
  rvcd_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (in_xfer),
    .data_byte (in_data_byte),
    .tap_w1    (win[1]),
    .tap_w2    (win[2]),
    .tap_w18   (win[LAST]),
    .hit       (hit)
  );

  // Result valid: set on a match, drop once the receiver takes it.
  always_comb begin
    if (hit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture fields at post-shift positions from the pre-shift taps: new position p is old p+1.
  always_ff @(posedge clk) begin
    if (hit) begin
      idx_r   <= win[3];
      yaw_r   <= {win[5],  win[4]};
      pitch_r <= {win[7],  win[6]};
      roll_r  <= {win[9],  win[8]};
      ax_r    <= {win[11], win[10]};
      ay_r    <= {win[13], win[12]};
      az_r    <= {win[15], win[14]};
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_index = idx_r;
  assign out_yaw         = yaw_r;
  assign out_pitch       = pitch_r;
  assign out_roll        = roll_r;
  assign out_accel_x     = ax_r;
  assign out_accel_y     = ay_r;
  assign out_accel_z     = az_r;

`ifndef NO_ASSERTIONS
  a_hit_needs_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> in_xfer)
    else $error("frame match without a byte transfer");

  a_stall_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result pending");

  a_hit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    hit |=> out_valid && (out_frame_index == $past(win[3])))
    else $error("matched frame not loaded into result register");
`endif

endmodule

[tb/sv/tb_rvc_frame_deframer_core.sv]
// Testbench for the RVC frame deframer: byte stream stimulus, frame prediction and checking.
`timescale 1ns / 1ps

module tb_rvc_frame_deframer_core;

  // Cycle budget for the run, far above what a clean run needs.
  localparam int RUN_LIMIT   = 200000;
  localparam int BYTE_TARGET = 1120;
  localparam int TAIL_CYCLES = 20;

  // Decoded frame as it leaves the block.
  typedef struct {
    rvcd_pkg::byte_t    index;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } frame_t;

  // Bytes 2 to 17 of a frame: index, six values, three reserved bytes.
  typedef rvcd_pkg::byte_t body_t[16];

  typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_SYNC} frame_kind_t;

  // Frame predictor and store of frames that the block still owes.
  class frame_scoreboard;
    rvcd_pkg::byte_t win[rvcd_pkg::FRAME_LEN];
    rvcd_pkg::cnt_t  fill;
    frame_t          owed_q[$];
    int              errors;
    int              bytes_seen;
    int              frames_checked;

    function new();
      fill           = '0;
      errors         = 0;
      bytes_seen     = 0;
      frames_checked = 0;
    endfunction

    // Shift one accepted byte into the window and queue a frame if it closes one.
    function void note_byte(rvcd_pkg::byte_t b);
      rvcd_pkg::byte_t sum;
      frame_t          f;
      bytes_seen++;
      if (fill == rvcd_pkg::CNT_FULL) begin
        for (int i = 0; i < rvcd_pkg::FRAME_LEN - 1; i++) win[i] = win[i + 1];
        win[rvcd_pkg::FRAME_LEN - 1] = b;
      end else begin
        win[fill] = b;
        fill++;
      end
      if (fill != rvcd_pkg::CNT_FULL) return;
      if (win[0] != rvcd_pkg::SYNC_BYTE || win[1] != rvcd_pkg::SYNC_BYTE) return;
      sum = '0;
      for (int k = 2; k < rvcd_pkg::FRAME_LEN - 1; k++) sum = sum + win[k];
      if (sum != win[rvcd_pkg::FRAME_LEN - 1]) return;
      f.index   = win[2];
      f.yaw     = {win[4], win[3]};
      f.pitch   = {win[6], win[5]};
      f.roll    = {win[8], win[7]};
      f.accel_x = {win[10], win[9]};
      f.accel_y = {win[12], win[11]};
      f.accel_z = {win[14], win[13]};
      owed_q.push_back(f);
      fill = '0;
    endfunction

    function void match(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    // Compare a frame taken from the block with the oldest owed frame.
    function void check_frame(frame_t got);
      frame_t want;
      if (owed_q.size() == 0) begin
        $error("frame with index %0d arrived with none owed", got.index);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      frames_checked++;
      match("frame_index", want.index, got.index);
      match("yaw", want.yaw, got.yaw);
      match("pitch", want.pitch, got.pitch);
      match("roll", want.roll, got.roll);
      match("accel_x", want.accel_x, got.accel_x);
      match("accel_y", want.accel_y, got.accel_y);
      match("accel_z", want.accel_z, got.accel_z);
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_frame_index;
  logic signed [15:0] out_yaw;
  logic signed [15:0] out_pitch;
  logic signed [15:0] out_roll;
  logic signed [15:0] out_accel_x;
  logic signed [15:0] out_accel_y;
  logic signed [15:0] out_accel_z;

  frame_scoreboard sb;
  int cycles        = 0;
  int idle_pct      = 21;
  int stall_pct     = 21;
  int frames_sent   = 0;
  int frames_flawed = 0;

  rvc_frame_deframer_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_index (out_frame_index),
    .out_yaw         (out_yaw),
    .out_pitch       (out_pitch),
    .out_roll        (out_roll),
    .out_accel_x     (out_accel_x),
    .out_accel_y     (out_accel_y),
    .out_accel_z     (out_accel_z)
  );

  always #6 clk = ~clk;

  // Count cycles and abort the run once the budget is spent.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("Timeout after %0d cycles with %0d frames still owed", cycles, sb.owed());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Back-pressure the result channel at random; drive on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Sample every result transfer at the rising edge and check it.
  always @(posedge clk) begin
    frame_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.index   = out_frame_index;
      got.yaw     = out_yaw;
      got.pitch   = out_pitch;
      got.roll    = out_roll;
      got.accel_x = out_accel_x;
      got.accel_y = out_accel_y;
      got.accel_z = out_accel_z;
      sb.check_frame(got);
    end
  end

  // Random byte, biased toward the sync value and the 16-bit extremes.
  function automatic rvcd_pkg::byte_t pick_byte();
    rvcd_pkg::byte_t edges[4];
    edges = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    case ($urandom_range(9))
      0:       return rvcd_pkg::SYNC_BYTE;
      1:       return edges[$urandom_range(3)];
      default: return rvcd_pkg::byte_t'($urandom_range(255));
    endcase
  endfunction

  // Send one byte. Enter and leave on a falling edge; hold the byte until
  // its transfer, and idle before it at random.
  task automatic send_byte(input rvcd_pkg::byte_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  // Wrap a body in sync bytes and checksum, corrupting one of them if asked.
  task automatic send_frame(input body_t body, input frame_kind_t kind);
    rvcd_pkg::byte_t sum;
    rvcd_pkg::byte_t sync0;
    rvcd_pkg::byte_t sync1;
    rvcd_pkg::byte_t bad;
    sum   = '0;
    sync0 = rvcd_pkg::SYNC_BYTE;
    sync1 = rvcd_pkg::SYNC_BYTE;
    foreach (body[i]) sum = sum + body[i];
    bad = rvcd_pkg::byte_t'($urandom_range(255));
    if (bad == rvcd_pkg::SYNC_BYTE) bad = ~bad;
    case (kind)
      FRAME_BAD_SUM: sum = sum + rvcd_pkg::byte_t'($urandom_range(1, 255));
      FRAME_BAD_SYNC: begin
        case ($urandom_range(2))
          0:       sync0 = bad;
          1:       sync1 = bad;
          default: begin
            sync0 = bad;
            sync1 = bad;
          end
        endcase
      end
      default: ;
    endcase
    frames_sent++;
    if (kind != FRAME_GOOD) frames_flawed++;
    send_byte(sync0);
    send_byte(sync1);
    foreach (body[i]) send_byte(body[i]);
    send_byte(sum);
  endtask

  initial begin
    body_t body;
    int    pick;
    int    burst;
    sb = new();

    // Hold reset, then release it on a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: two stray bytes so the frame completes only after the
    // window has started to slide, then a frame with extreme values and
    // sync bytes inside the payload and the reserved bytes.
    send_byte(8'h00);
    send_byte(8'hFF);
    body = '{8'hFF,
             8'h00, 8'h80,
             8'hFF, 8'h7F,
             8'hFF, 8'hFF,
             8'h00, 8'h00,
             8'h01, 8'h00,
             rvcd_pkg::SYNC_BYTE, rvcd_pkg::SYNC_BYTE,
             rvcd_pkg::SYNC_BYTE, 8'h00, 8'hFF};
    send_frame(body, FRAME_GOOD);

    // Random part: mostly well-formed frames with random content, the rest
    // corrupted frames and bursts of line noise. Drop all idling on both
    // channels for a long stretch in the middle.
    while (sb.bytes_seen < BYTE_TARGET) begin
      if (sb.bytes_seen >= 400 && sb.bytes_seen < 700) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 21;
        stall_pct = 21;
      end
      pick = $urandom_range(99);
      if (pick < 82) begin
        foreach (body[i]) body[i] = pick_byte();
        if (pick < 65)
          send_frame(body, FRAME_GOOD);
        else if (pick < 75)
          send_frame(body, FRAME_BAD_SUM);
        else
          send_frame(body, FRAME_BAD_SYNC);
      end else begin
        burst = $urandom_range(1, 5);
        repeat (burst) send_byte(pick_byte());
      end
    end
    in_valid = 1'b0;

    // Drain: wait for every owed frame, then watch for stray results.
    while (sb.owed() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d byte transfers carrying %0d frames, %0d of them corrupted.",
             sb.bytes_seen, frames_sent, frames_flawed);
    $display("Checked %0d decoded frames field by field; %0d mismatches.",
             sb.frames_checked, sb.errors);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
